### sv/salct_pkg.sv
// Shared types, constants and address helpers for the cache tag store.
// No dependencies; used by every other file of the block except salct_ram.
`default_nettype none
package salct_pkg;

   localparam int ADDR_BITS   = 8;
   localparam int WAYS        = 8;
   localparam int SETS        = 4;
   localparam int BLOCK_BYTES = 4;

   localparam int OFFSET_BITS = $clog2(BLOCK_BYTES);
   localparam int SET_BITS    = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int TAG_BITS    = ADDR_BITS - OFFSET_BITS - $clog2(SETS);
   localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int AGE_BITS    = WAY_BITS;
   localparam int ROW_BITS    = WAYS * (1 + TAG_BITS + AGE_BITS);

   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [SET_BITS-1:0]  set_type;
   typedef logic [TAG_BITS-1:0]  tag_type;
   typedef logic [WAY_BITS-1:0]  way_type;
   typedef logic [AGE_BITS-1:0]  age_type;

   // one set of the tag store, as held in one memory word
   typedef struct packed {
      logic    [WAYS-1:0] valid;
      tag_type [WAYS-1:0] tag;
      age_type [WAYS-1:0] age;
   } row_type;

   typedef struct packed {
      logic    hit;
      way_type way;
      row_type row;
   } lookup_type;

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   function automatic set_type addr_set(input addr_type address);
      addr_type block;
      block = address >> OFFSET_BITS;
      return set_type'(block % SETS);
   endfunction

   function automatic tag_type addr_tag(input addr_type address);
      addr_type upper;
      upper = address >> (OFFSET_BITS + $clog2(SETS));
      return tag_type'(upper);
   endfunction

endpackage
`default_nettype wire

### sv/salct_ifs.sv
// Valid/ready channel interfaces for the access (request) and result (response) words.
// Depends on salct_pkg.
`default_nettype none
interface salct_req_if;
   import salct_pkg::*;
   logic     valid;
   logic     ready;
   addr_type address;
   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

interface salct_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   modport source (output valid, output hit, input ready);
   modport sink   (input valid, input hit, output ready);
endinterface
`default_nettype wire

### sv/set_assoc_lru_cache_tags.sv
// Tag store of a set-associative cache with LRU replacement (top level).
// Depends on salct_pkg, salct_ifs, salct_ram and salct_update.
//
// Usage:
//   req: one word per access, carrying the byte address. The address splits
//        into block offset, set number and tag.
//   rsp: one word per access, carrying hit (1 when a valid way of the set
//        held the tag, 0 when the access missed and filled a way).
// Each access reads the set row from the row memory in the accept cycle and
// compares, updates and writes it back in the next. The registered read data
// of that memory and the read-modify-write of a whole set per access mean a
// new access is accepted only after the previous one has been written back.
// The response sits in an output register; req_ch.ready stays high in the
// idle state while that register is empty or being drained, so a stalled
// receiver holds at most one response and blocks further accesses.
// Reset clears the per-set written flags, so every set reads as empty with
// no valid ways; there is no clearing pass and the block is ready in the
// first cycle after reset.
`default_nettype none
module set_assoc_lru_cache_tags (
   input wire logic  clock,
   input wire logic  reset,
   salct_req_if.sink   req_ch,
   salct_rsp_if.source rsp_ch
);
   import salct_pkg::*;

   state_type     state_ff, state_in;
   set_type       set_ff, set_in;
   tag_type       tag_ff, tag_in;
   logic [SETS-1:0] row_written_ff, row_written_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_hit_ff, rsp_hit_in;
   logic          accept;
   logic [ROW_BITS-1:0] rd_data;
   row_type       row_cur;
   lookup_type    upd;

   assign req_ch.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;

   salct_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (SETS)
   ) u_rows (
      .clock   (clock),
      .wr_en   (state_ff == ST_LOOKUP),
      .wr_addr (set_ff),
      .wr_data (upd.row),
      .rd_en   (accept),
      .rd_addr (addr_set(req_ch.address)),
      .rd_data (rd_data)
   );

   assign row_cur = row_written_ff[set_ff] ? row_type'(rd_data) : '0;

   salct_update u_update (
      .row_in (row_cur),
      .tag    (tag_ff),
      .result (upd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         row_written_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         row_written_ff <= row_written_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      set_ff     <= set_in;
      tag_ff     <= tag_in;
      rsp_hit_ff <= rsp_hit_in;
   end

   always_comb begin
      state_in       = state_ff;
      set_in         = set_ff;
      tag_in         = tag_ff;
      row_written_in = row_written_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_hit_in     = rsp_hit_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOKUP;
               set_in   = addr_set(req_ch.address);
               tag_in   = addr_tag(req_ch.address);
            end
         end
         ST_LOOKUP: begin
            state_in               = ST_IDLE;
            row_written_in[set_ff] = 1'b1;
            rsp_valid_in           = 1'b1;
            rsp_hit_in             = upd.hit;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.hit   = rsp_hit_ff;

   a_lookup_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOKUP |-> !rsp_valid_ff)
      else $error("response register busy during lookup");

   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_LOOKUP)
      else $error("accepted word did not enter lookup");

   a_lookup_to_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOKUP |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("lookup did not produce a response");

   a_touched_way_mru: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOKUP |-> upd.row.valid[upd.way] && upd.row.age[upd.way] == '0)
      else $error("touched way not valid and most recent");

   a_set_marked: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOKUP |=> row_written_ff[$past(set_ff)])
      else $error("written set not marked");

endmodule
`default_nettype wire

### sv/salct_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module salct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### sv/salct_update.sv
// Way compare, victim choice and LRU rank update for one set row.
// Depends on salct_pkg.
`default_nettype none
module salct_update (
   input  wire salct_pkg::row_type    row_in,
   input  wire salct_pkg::tag_type    tag,
   output      salct_pkg::lookup_type result
);
   import salct_pkg::*;

   always_comb begin
      logic    hit;
      logic    found;
      way_type way;
      age_type best_age;
      logic    was_valid;
      age_type old_age;
      row_type row;

      row   = row_in;
      hit   = 1'b0;
      found = 1'b0;
      way   = '0;
      best_age = '0;

      for (int k = 0; k < WAYS; k++) begin
         if (!hit && row_in.valid[k] && row_in.tag[k] == tag) begin
            hit = 1'b1;
            way = WAY_BITS'(k);
         end
      end

      if (!hit) begin
         for (int k = 0; k < WAYS; k++) begin
            if (!found && !row_in.valid[k]) begin
               found = 1'b1;
               way   = WAY_BITS'(k);
            end
         end
         if (!found) begin
            for (int k = 0; k < WAYS; k++) begin
               if (row_in.age[k] > best_age) begin
                  best_age = row_in.age[k];
                  way      = WAY_BITS'(k);
               end
            end
         end
      end

      was_valid = row_in.valid[way];
      old_age   = row_in.age[way];
      for (int k = 0; k < WAYS; k++) begin
         if (WAY_BITS'(k) != way && row_in.valid[k] &&
             (!was_valid || row_in.age[k] < old_age)) begin
            row.age[k] = row_in.age[k] + 1'b1;
         end
      end
      row.age[way]   = '0;
      row.valid[way] = 1'b1;
      if (!hit) begin
         row.tag[way] = tag;
      end

      result.hit = hit;
      result.way = way;
      result.row = row;
   end

endmodule
`default_nettype wire

### dv/salct_tag_checker.sv
// Hit checker for the cache tag store: watches both channels, tracks its own copy of the
// tag store, and compares each response hit against the access that caused it.
// Depends on salct_pkg and salct_ifs.
`default_nettype none
module salct_tag_checker (
   input  wire logic clock,
   input  wire logic reset,
   salct_req_if      req_ch,
   salct_rsp_if      rsp_ch,
   output int        failures,
   output int        backlog
);
   import salct_pkg::*;

   logic    line_ok   [SETS][WAYS];
   tag_type line_key  [SETS][WAYS];
   age_type line_rank [SETS][WAYS];
   logic    expected_hits [$];
   int      fail_total = 0;
   int      wait_total = 0;

   assign failures = fail_total;
   assign backlog  = wait_total;

   task automatic report_mismatch(input string msg);
      $display("[%0t] hit check: %s", $time, msg);
      fail_total++;
   endtask

   // look the address up, apply the LRU update or fill, return the hit flag
   function automatic logic lookup_and_fill(input addr_type address);
      int      s;
      tag_type t;
      int      way;
      logic    found;
      logic    was_valid;
      age_type old_rank;
      age_type worst;
      s     = (address >> OFFSET_BITS) % SETS;
      t     = tag_type'(address >> (OFFSET_BITS + SET_BITS));
      found = 1'b0;
      way   = -1;
      for (int k = 0; k < WAYS; k++) begin
         if (!found && line_ok[s][k] && line_key[s][k] == t) begin
            found = 1'b1;
            way   = k;
         end
      end
      if (!found) begin
         for (int k = 0; k < WAYS; k++) begin
            if (way < 0 && !line_ok[s][k]) way = k;
         end
         if (way < 0) begin
            worst = '0;
            way   = 0;
            for (int k = 0; k < WAYS; k++) begin
               if (line_rank[s][k] > worst) begin
                  worst = line_rank[s][k];
                  way   = k;
               end
            end
         end
      end
      was_valid = line_ok[s][way];
      old_rank  = line_rank[s][way];
      for (int k = 0; k < WAYS; k++) begin
         if (k != way && line_ok[s][k] && (!was_valid || line_rank[s][k] < old_rank))
            line_rank[s][k] = line_rank[s][k] + 1'b1;
      end
      line_rank[s][way] = '0;
      line_key[s][way]  = t;
      line_ok[s][way]   = 1'b1;
      return found;
   endfunction

   always @(posedge clock) begin : watch
      logic want;
      if (reset) begin
         for (int s = 0; s < SETS; s++) begin
            for (int k = 0; k < WAYS; k++) begin
               line_ok[s][k]   = 1'b0;
               line_rank[s][k] = '0;
            end
         end
         expected_hits.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_hits.size() == 0) begin
               report_mismatch($sformatf("hit=%0b with no access pending", rsp_ch.hit));
            end else begin
               want = expected_hits.pop_front();
               if (rsp_ch.hit !== want)
                  report_mismatch($sformatf("hit=%0b, expected %0b", rsp_ch.hit, want));
            end
         end
         if (req_ch.valid && req_ch.ready)
            expected_hits.push_back(lookup_and_fill(req_ch.address));
      end
      wait_total = expected_hits.size();
   end

endmodule
`default_nettype wire

### dv/tb_top.sv
// Top of the cache tag store testbench: clock, reset, access stimulus and response
// back-pressure, with the verdict taken from the hit checker.
// Depends on salct_pkg, salct_ifs, set_assoc_lru_cache_tags and salct_tag_checker.
`default_nettype none
module tb_top;
   import salct_pkg::*;

   localparam addr_type DIRECTED [19] = '{
      8'h00, 8'hFF, 8'h03, 8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'h60, 8'h70,
      8'h01, 8'h32, 8'h80, 8'h10, 8'h02, 8'hFC, 8'hF0, 8'hAA, 8'h55
   };
   localparam int RANDOM_PER_PHASE = 435;
   localparam int HOLD_CYCLES      = 300;

   logic clock      = 1'b0;
   logic reset      = 1'b1;
   logic hold_start = 1'b0;
   int   hold_left  = 0;
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   int   failures;
   int   backlog;

   salct_req_if req_ch();
   salct_rsp_if rsp_ch();

   set_assoc_lru_cache_tags dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   salct_tag_checker hit_watch (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .failures (failures),
      .backlog  (backlog)
   );

   always #6 clock = ~clock;

   initial begin
      #4000000;
      $display("Test completed with failures");
      $finish;
   end

   // response side: random stalls, or a long hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (hold_start) begin
            rsp_ch.ready <= 1'b0;
            hold_left = HOLD_CYCLES;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   task automatic send_word(input addr_type address);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.address <= address;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (backlog != 0);
   endtask

   initial begin
      int       window_base;
      addr_type address;
      req_ch.valid   = 1'b0;
      req_ch.address = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) send_word(DIRECTED[i]);
      drain();

      // long receiver hold-off while accesses keep coming
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      repeat (24) send_word(addr_type'($urandom_range(255)));
      drain();

      window_base = 0;
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 71; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 71; end
            default: begin send_idle_pct = 36; rsp_stall_pct = 36; end
         endcase
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            if (i % 60 == 0) window_base = $urandom_range(15);
            // mostly a sliding window of ~10 tags so sets fill and evict
            if ($urandom_range(99) < 40)
               address = addr_type'($urandom_range(255));
            else
               address = {tag_type'(window_base + $urandom_range(9)),
                          set_type'($urandom_range(SETS - 1)),
                          OFFSET_BITS'($urandom_range(BLOCK_BYTES - 1))};
            send_word(address);
         end
         drain();
      end

      repeat (4) @(posedge clock);
      if (failures == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
`default_nettype wire

### files.f
sv/salct_pkg.sv
sv/salct_ifs.sv
sv/salct_ram.sv
sv/salct_update.sv
sv/set_assoc_lru_cache_tags.sv
dv/salct_tag_checker.sv
dv/tb_top.sv
